// ----- sv/otb_pkg.sv -----
package otb_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    localparam int IDX_W   = 4;
    localparam int DELAY_W = 32;
    localparam int MODE_W  = 2;
    localparam int MASK_W  = 16;
    localparam int COUNT_W = 16;
    localparam int TICK_W  = 32;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_ARM  = 1'b1
    } op_t;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_IDLE    = 2'd0;
    localparam mode_t MODE_RUNNING = 2'd1;
    localparam mode_t MODE_EXPIRED = 2'd2;

    typedef struct packed {
        op_t                op;
        logic [IDX_W-1:0]   timer_index;
        logic [DELAY_W-1:0] delay_ticks;
        mode_t              new_state;
    } otb_cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0]  expired_mask;
        mode_t              indexed_state;
        logic [COUNT_W-1:0] indexed_expiry_count;
    } otb_res_t;

endpackage

// ----- sv/otb_timer_bank.sv -----
module otb_timer_bank #(
    parameter int NUM_TIMERS = otb_pkg::NUM_TIMERS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  otb_pkg::otb_cmd_t cmd,
    output otb_pkg::otb_res_t res
);

    logic [otb_pkg::TICK_W-1:0]  tick_count_reg, tick_count_next;
    otb_pkg::mode_t              mode_reg     [NUM_TIMERS];
    otb_pkg::mode_t              mode_next    [NUM_TIMERS];
    logic [otb_pkg::TICK_W-1:0]  deadline_reg [NUM_TIMERS];
    logic [otb_pkg::TICK_W-1:0]  deadline_next[NUM_TIMERS];
    logic [otb_pkg::COUNT_W-1:0] count_reg    [NUM_TIMERS];
    logic [otb_pkg::COUNT_W-1:0] count_next   [NUM_TIMERS];

    always_comb begin
        tick_count_next = tick_count_reg;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            mode_next[i]     = mode_reg[i];
            deadline_next[i] = deadline_reg[i];
            count_next[i]    = count_reg[i];
        end
        res = '0;

        if (step_en) begin
            if (cmd.op == otb_pkg::OP_TICK) begin
                tick_count_next = tick_count_reg + 32'd1;
                // every timer has its own comparator against the new count
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (mode_reg[i] == otb_pkg::MODE_RUNNING &&
                        deadline_reg[i] <= tick_count_next) begin
                        mode_next[i]  = otb_pkg::MODE_EXPIRED;
                        count_next[i] = count_reg[i] + 16'd1;
                        if (i < otb_pkg::MASK_W) begin
                            res.expired_mask[i % otb_pkg::MASK_W] = 1'b1;
                        end
                    end
                end
            end else begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (i < (1 << otb_pkg::IDX_W) &&
                        cmd.timer_index == otb_pkg::IDX_W'(i)) begin
                        mode_next[i] = cmd.new_state;
                        if (cmd.new_state == otb_pkg::MODE_IDLE) begin
                            count_next[i] = '0;
                        end
                        if (cmd.delay_ticks != '0) begin
                            deadline_next[i] = tick_count_reg + cmd.delay_ticks;
                        end
                    end
                end
            end
        end

        // index past the bank reports zero
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (i < (1 << otb_pkg::IDX_W) && cmd.timer_index == otb_pkg::IDX_W'(i)) begin
                res.indexed_state        = mode_next[i];
                res.indexed_expiry_count = count_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                mode_reg[i]     <= otb_pkg::MODE_IDLE;
                deadline_reg[i] <= '0;
                count_reg[i]    <= '0;
            end
        end else begin
            tick_count_reg <= tick_count_next;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                mode_reg[i]     <= mode_next[i];
                deadline_reg[i] <= deadline_next[i];
                count_reg[i]    <= count_next[i];
            end
        end
    end

    a_arm_no_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && cmd.op == otb_pkg::OP_ARM |-> res.expired_mask == '0)
        else $error("expiry flagged on an arm item");

    a_tick_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && cmd.op == otb_pkg::OP_TICK
        |=> tick_count_reg == $past(tick_count_reg) + 32'd1)
        else $error("tick count did not advance by one");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step_en && cmd.op == otb_pkg::OP_TICK) |=> $stable(tick_count_reg))
        else $error("tick count moved without a tick");

endmodule

// ----- sv/oneshot_timer_bank_core.sv -----
// Bank of one-shot timers sharing a 32-bit tick count that each tick transfer advances.
// Each input transfer is a tick (tuser 0) or an arm of one timer (tuser 1); every transfer
// gives exactly one result with the expiry mask of that tick and the state and expiry
// count of the indexed timer. The block takes one transfer per clock while the result side
// does not stall it. The accepting edge loads the input register, and once the result
// register is free or being read, one pass through the per-timer comparators and update logic
// fills the result register, which then offers the result. Each timer has its own deadline
// comparator, so the bank size does not change the rate. Backpressure on the result side
// stalls the input only once both registers are full.
module oneshot_timer_bank_core #(
    parameter int NUM_TIMERS = otb_pkg::NUM_TIMERS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // timer_index[3:0], delay_ticks[35:4], new_state[37:36], zero fill
    input  logic [otb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // op
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // expired_mask[15:0], indexed_state[17:16], indexed_expiry_count[33:18], zero fill
    output logic [otb_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    logic               s1_valid_reg;
    otb_pkg::otb_cmd_t  s1_cmd_reg;
    logic               out_valid_reg;
    otb_pkg::otb_res_t  out_res_reg;
    otb_pkg::otb_res_t  bank_res;
    otb_pkg::otb_cmd_t  in_cmd;
    logic               advance;

    assign advance       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;

    always_comb begin
        in_cmd.op          = otb_pkg::op_t'(s_axis_tuser);
        in_cmd.timer_index = s_axis_tdata[3:0];
        in_cmd.delay_ticks = s_axis_tdata[35:4];
        in_cmd.new_state   = s_axis_tdata[37:36];
    end

    otb_timer_bank #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_bank (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step_en(advance),
        .cmd    (s1_cmd_reg),
        .res    (bank_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            s1_cmd_reg <= in_cmd;
        end
        if (advance) begin
            out_res_reg <= bank_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        {(otb_pkg::M_TDATA_W - $bits(otb_pkg::otb_res_t)){1'b0}},
        out_res_reg.indexed_expiry_count,
        out_res_reg.indexed_state,
        out_res_reg.expired_mask
    };

    a_stall_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && out_valid_reg && !m_axis_tready |=> s1_valid_reg)
        else $error("held item lost while result side stalled");

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed item did not reach the result register");

    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted with both registers full");

endmodule

// ----- tb/sv/tb.sv -----
module tb;

    localparam int NUM_TIMERS   = otb_pkg::NUM_TIMERS_DEF;
    localparam int WATCHDOG_MAX = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam otb_pkg::mode_t MODE_RESERVED = 2'd3;

    logic                          aclk;
    logic                          aresetn       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // timer_index[3:0], delay_ticks[35:4], new_state[37:36], zero fill
    logic [otb_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    // op
    logic                          s_axis_tuser  = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // expired_mask[15:0], indexed_state[17:16], indexed_expiry_count[33:18], zero fill
    logic [otb_pkg::M_TDATA_W-1:0] m_axis_tdata;

    oneshot_timer_bank_core #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // own copy of the timer bank
    logic [otb_pkg::TICK_W-1:0]  tick_now;
    otb_pkg::mode_t              timer_mode_q [NUM_TIMERS];
    logic [otb_pkg::TICK_W-1:0]  deadline_q   [NUM_TIMERS];
    logic [otb_pkg::COUNT_W-1:0] fired_q      [NUM_TIMERS];

    otb_pkg::otb_res_t pending_results[$];

    int  err_cnt      = 0;
    int  n_ticks      = 0;
    int  n_arms       = 0;
    int  n_expiries   = 0;
    int  n_results    = 0;
    int  n_holds      = 0;
    int  idle_cycles  = 0;
    bit  sender_gaps  = 1'b0;
    bit  sink_random  = 1'b0;
    bit  sink_hold    = 1'b0;
    int  stall_left   = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic otb_pkg::otb_res_t step_bank(otb_pkg::op_t op,
                                                    logic [otb_pkg::IDX_W-1:0] idx,
                                                    logic [otb_pkg::DELAY_W-1:0] delay,
                                                    otb_pkg::mode_t mode);
        otb_pkg::otb_res_t r;
        r = '0;
        if (op == otb_pkg::OP_TICK) begin
            tick_now = tick_now + 1'b1;
            n_ticks++;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (timer_mode_q[i] == otb_pkg::MODE_RUNNING && deadline_q[i] <= tick_now) begin
                    timer_mode_q[i] = otb_pkg::MODE_EXPIRED;
                    fired_q[i]      = fired_q[i] + 1'b1;
                    if (i < otb_pkg::MASK_W)
                        r.expired_mask[i] = 1'b1;
                    n_expiries++;
                end
            end
        end else begin
            n_arms++;
            if (idx < NUM_TIMERS) begin
                timer_mode_q[idx] = mode;
                if (mode == otb_pkg::MODE_IDLE)
                    fired_q[idx] = '0;
                if (delay != '0)
                    deadline_q[idx] = tick_now + delay;
            end
        end
        if (idx < NUM_TIMERS) begin
            r.indexed_state        = timer_mode_q[idx];
            r.indexed_expiry_count = fired_q[idx];
        end
        return r;
    endfunction

    // predict on every accepted input transfer
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            pending_results.push_back(step_bank(otb_pkg::op_t'(s_axis_tuser),
                                                s_axis_tdata[3:0], s_axis_tdata[35:4],
                                                s_axis_tdata[37:36]));
    end

    // result checker
    always @(posedge aclk) begin
        otb_pkg::otb_res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: tdata %h", m_axis_tdata);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[15:0] !== want.expired_mask) begin
                    $error("expired_mask: expected %h, got %h",
                           want.expired_mask, m_axis_tdata[15:0]);
                    err_cnt++;
                end
                if (m_axis_tdata[17:16] !== want.indexed_state) begin
                    $error("indexed_state: expected %0d, got %0d",
                           want.indexed_state, m_axis_tdata[17:16]);
                    err_cnt++;
                end
                if (m_axis_tdata[33:18] !== want.indexed_expiry_count) begin
                    $error("indexed_expiry_count: expected %0d, got %0d",
                           want.indexed_expiry_count, m_axis_tdata[33:18]);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on transfers from either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_MAX);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side ready, with random stalls and an occasional long hold
    initial begin
        forever begin
            @(posedge aclk);
            if (sink_hold) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                sink_hold = 1'b0;
                n_holds++;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (sink_random) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    m_axis_tready <= 1'b0;
                    stall_left = $urandom_range(0, 2);
                end else if (r < 18) begin
                    m_axis_tready <= 1'b0;
                    stall_left = $urandom_range(10, 40);
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // called at a rising edge; returns at the edge where the transfer is taken
    task automatic send_item(otb_pkg::op_t op, logic [otb_pkg::IDX_W-1:0] idx,
                             logic [otb_pkg::DELAY_W-1:0] delay, otb_pkg::mode_t mode);
        int r;
        int gap;
        gap = 0;
        if (sender_gaps) begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(10, 30);
            else if (r >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, mode, delay, idx};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic tick(logic [otb_pkg::IDX_W-1:0] idx);
        send_item(otb_pkg::OP_TICK, idx, $urandom, otb_pkg::mode_t'($urandom_range(0, 3)));
    endtask

    task automatic arm(logic [otb_pkg::IDX_W-1:0] idx, logic [otb_pkg::DELAY_W-1:0] delay,
                       otb_pkg::mode_t mode);
        send_item(otb_pkg::OP_ARM, idx, delay, mode);
    endtask

    task automatic test_directed;
        arm(4'd0, 32'd1, otb_pkg::MODE_RUNNING);
        tick(4'd0);                                  // timer 0 expires on the first tick
        arm(4'd15, 32'hFFFF_FFFF, otb_pkg::MODE_RUNNING); // deadline wraps below the count
        tick(4'd15);
        arm(4'd5, 32'd2, MODE_RESERVED);             // never checked by a tick
        tick(4'd5);
        tick(4'd5);
        tick(4'd5);
        arm(4'd0, 32'd0, otb_pkg::MODE_RUNNING);     // keeps the old, already passed deadline
        tick(4'd0);
        arm(4'd0, 32'd0, otb_pkg::MODE_IDLE);        // idle clears the expiry count
        arm(4'd7, 32'd0, otb_pkg::MODE_EXPIRED);
        arm(4'd10, 32'h5555_5555, otb_pkg::MODE_RUNNING);
        arm(4'd9, 32'hAAAA_AAAA, otb_pkg::MODE_RUNNING);
        arm(4'd3, 32'd3, otb_pkg::MODE_RUNNING);
        arm(4'd4, 32'd3, otb_pkg::MODE_RUNNING);
        tick(4'd3);
        tick(4'd4);
        tick(4'd3);                                  // two timers expire together
        arm(4'd12, 32'd1, otb_pkg::MODE_RUNNING);
        arm(4'd12, 32'd0, otb_pkg::MODE_RUNNING);
        tick(4'd12);
        arm(4'd12, 32'd1, otb_pkg::MODE_RUNNING);    // rearm after expiry, count goes to two
        tick(4'd12);
    endtask

    task automatic random_item;
        int r;
        logic [otb_pkg::DELAY_W-1:0] delay;
        otb_pkg::mode_t mode;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            tick(4'($urandom_range(0, 15)));
        end else begin
            r = $urandom_range(0, 99);
            if (r < 10)
                delay = '0;
            else if (r < 60)
                delay = $urandom_range(1, 8);
            else if (r < 80)
                delay = $urandom_range(1, 64);
            else if (r < 90)
                delay = $urandom;
            else
                delay = 32'hFFFF_FFFF - $urandom_range(0, 8);
            r = $urandom_range(0, 99);
            if (r < 70)
                mode = otb_pkg::MODE_RUNNING;
            else if (r < 80)
                mode = otb_pkg::MODE_IDLE;
            else if (r < 90)
                mode = otb_pkg::MODE_EXPIRED;
            else
                mode = MODE_RESERVED;
            arm(4'($urandom_range(0, 15)), delay, mode);
        end
    endtask

    task automatic test_full_rate;
        sender_gaps = 1'b0;
        sink_random = 1'b0;
        repeat (100) random_item();
    endtask

    task automatic test_backpressure;
        sender_gaps = 1'b0;
        sink_random = 1'b0;
        sink_hold   = 1'b1;
        repeat (40) random_item();
    endtask

    task automatic test_random;
        sender_gaps = 1'b1;
        sink_random = 1'b1;
        repeat (1000) random_item();
    endtask

    initial begin
        tick_now = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            timer_mode_q[i] = otb_pkg::MODE_IDLE;
            deadline_q[i]   = '0;
            fired_q[i]      = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_rate();
        test_backpressure();
        test_random();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d ticks and %0d arms, %0d timer expiries, %0d results checked",
                 n_ticks, n_arms, n_expiries, n_results);
        $display("random gaps on both sides, %0d long result-side hold(s)", n_holds);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/otb_pkg.sv
sv/otb_timer_bank.sv
sv/oneshot_timer_bank_core.sv
tb/sv/tb.sv
